@@ rtl/core/mrfc_pkg.sv @@
`default_nettype none

package mrfc_pkg;

	// Frame layout
	localparam int unsigned PosWidth = 3;
	localparam logic [PosWidth-1:0] PosAddr = 3'd0;
	localparam logic [PosWidth-1:0] PosReg  = 3'd3;
	localparam logic [PosWidth-1:0] PosCrcEnd = 3'd6;   // bytes below this feed the CRC
	localparam logic [PosWidth-1:0] PosLast = 3'd7;

	// CRC-16/MODBUS
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	// Configuration registers
	localparam logic [7:0]  ResetSlaveAddress = 8'h04;
	localparam logic [15:0] ResetExpectedCrc  = 16'h605F;
	localparam int unsigned CfgIdxWidth  = 1;
	localparam int unsigned CfgDataWidth = 16;
	localparam logic [CfgIdxWidth-1:0] CfgSlaveAddress = 1'd0;
	localparam logic [CfgIdxWidth-1:0] CfgExpectedCrc  = 1'd1;

	// Output beat packing
	localparam int unsigned OutDataWidth = 32;

	typedef struct packed {
		logic        addressed;
		logic        crc_ok;
		logic [7:0]  register_number;
		logic [15:0] computed_crc;
	} result_t;

	// One byte through the reflected CRC, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/modbus_request_frame_checker_unit.sv @@
// Path: input register, then result register on the eighth byte of a frame. Throughput:
// one byte per cycle unless a frame's last byte waits on a busy result register, one
// beat per 8 bytes; input and result registers each refill in the cycle they empty.
// Reset (arst_n low): frame position to byte 0, no frame matched, CRC to 0xFFFF,
// slave_address to 0x04, expected_crc to 0x605F, both beat registers empty.
`default_nettype none

module modbus_request_frame_checker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// addressed[0], crc_ok[1], register_number[9:2], computed_crc[25:10], zero pad
	output logic [mrfc_pkg::OutDataWidth-1:0] m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [mrfc_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  wire logic [mrfc_pkg::CfgDataWidth-1:0] cfg_data
);

	logic [7:0]  slave_address_q;
	logic [15:0] expected_crc_q;

	logic              hold_valid;
	logic [7:0]        hold_byte;
	logic              last_byte;
	logic              out_free;
	logic              take;
	mrfc_pkg::result_t result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= mrfc_pkg::ResetSlaveAddress;
			expected_crc_q  <= mrfc_pkg::ResetExpectedCrc;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrfc_pkg::CfgSlaveAddress: slave_address_q <= cfg_data[7:0];
				mrfc_pkg::CfgExpectedCrc:  expected_crc_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held byte moves on unless it closes a frame and the result slot is busy
	assign take = hold_valid && (!last_byte || out_free);

	mrfc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.take       (take),
		.hold_valid (hold_valid),
		.hold_byte  (hold_byte)
	);

	mrfc_frame_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (take),
		.rx_byte       (hold_byte),
		.slave_address (slave_address_q),
		.expected_crc  (expected_crc_q),
		.last_byte     (last_byte),
		.result        (result)
	);

	mrfc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && last_byte),
		.result    (result),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

@@ rtl/core/mrfc_in_stage.sv @@
`default_nettype none

module mrfc_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       take,      // downstream consumes the held beat
	output logic            hold_valid,
	output logic [7:0]      hold_byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// Refill as soon as the held beat leaves
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign hold_valid = valid_s1;
	assign hold_byte  = byte_s1;

endmodule

`default_nettype wire

@@ rtl/core/mrfc_frame_core.sv @@
`default_nettype none

module mrfc_frame_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  slave_address,
	input  wire logic [15:0] expected_crc,
	output logic             last_byte,
	output mrfc_pkg::result_t result
);

	logic [mrfc_pkg::PosWidth-1:0] pos_q;
	logic                          matched_q;
	logic [15:0]                   crc_q;
	logic [7:0]                    reg_q;

	logic        first;
	logic        match_now;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	// Per-byte frame logic
	always_comb begin
		first     = (pos_q == mrfc_pkg::PosAddr);
		match_now = first ? (rx_byte == slave_address) : matched_q;
		crc_base  = first ? mrfc_pkg::CrcInit : crc_q;
		crc_next  = (match_now && (pos_q < mrfc_pkg::PosCrcEnd))
			? mrfc_pkg::crc_byte(crc_base, rx_byte) : crc_base;
		last_byte = (pos_q == mrfc_pkg::PosLast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= mrfc_pkg::PosAddr;
			matched_q <= 1'b0;
			crc_q     <= mrfc_pkg::CrcInit;
		end else if (go) begin
			if (last_byte) begin
				pos_q     <= mrfc_pkg::PosAddr;
				matched_q <= 1'b0;
				crc_q     <= mrfc_pkg::CrcInit;
			end else begin
				pos_q     <= pos_q + 3'd1;
				matched_q <= match_now;
				crc_q     <= crc_next;
			end
		end
	end

	// Requested register number
	always_ff @(posedge clk) begin
		if (go && match_now && (pos_q == mrfc_pkg::PosReg)) begin
			reg_q <= rx_byte;
		end
	end

	// Result seen on the last byte of a frame
	always_comb begin
		result.addressed       = matched_q;
		result.crc_ok          = matched_q && (crc_q == expected_crc);
		result.register_number = matched_q ? reg_q : 8'h00;
		result.computed_crc    = matched_q ? crc_q : 16'h0000;
	end

endmodule

`default_nettype wire

@@ rtl/core/mrfc_out_reg.sv @@
`default_nettype none

module mrfc_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire mrfc_pkg::result_t result,
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [mrfc_pkg::OutDataWidth-1:0] out_data
);

	logic              valid_q;
	mrfc_pkg::result_t res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= result;
		end
	end

	assign out_valid = valid_q;
	// addressed, crc_ok, register_number, computed_crc from bit 0 up
	assign out_data = {6'd0, res_q.computed_crc, res_q.register_number,
		res_q.crc_ok, res_q.addressed};

endmodule

`default_nettype wire
